// ===== sv/fwd_pkg.sv =====
// ----------------------------------------------------------------------------
// fwd_pkg
// Shared types and constants for the byte queue with delete-by-value.
// ----------------------------------------------------------------------------
package fwd_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int OCC_W = 5;

    typedef logic [DEPTH-1:0] t_vec;
    typedef logic [CNT_W-1:0] t_cnt;
    typedef logic [7:0]       t_byte;

    typedef enum logic [1:0] {
        OP_APPEND = 2'd0,
        OP_POP    = 2'd1,
        OP_DELETE = 2'd2,
        OP_NOP    = 2'd3
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_EMPTY   = 2'd1,
        STAT_NOMATCH = 2'd2,
        STAT_FULL    = 2'd3
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } t_state;

    typedef struct packed {
        logic load;
        logic exec;
    } t_cmd;

endpackage

// ===== sv/fwd_ctrl.sv =====
// ----------------------------------------------------------------------------
// fwd_ctrl
// Sequencer: takes a command, runs the execute step, strobes the result.
// ----------------------------------------------------------------------------
module fwd_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    output logic          o_busy,
    output logic          o_done,
    output fwd_pkg::t_cmd o_cmd
);

    fwd_pkg::t_state r_state;
    fwd_pkg::t_state n_state;
    logic            r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= fwd_pkg::S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= o_cmd.exec;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd.load = 1'b0;
        o_cmd.exec = 1'b0;
        o_busy     = 1'b0;
        unique case (r_state)
            fwd_pkg::S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = fwd_pkg::S_EXEC;
                end
            end
            fwd_pkg::S_EXEC: begin
                o_busy     = 1'b1;
                o_cmd.exec = 1'b1;
                n_state    = fwd_pkg::S_IDLE;
            end
            default: begin
                n_state = fwd_pkg::S_IDLE;
            end
        endcase
    end

    assign o_done = r_done;

endmodule

// ===== sv/fwd_datapath.sv =====
// ----------------------------------------------------------------------------
// fwd_datapath
// Row of byte slots with parallel compare, shift-toward-head and result regs.
// ----------------------------------------------------------------------------
module fwd_datapath (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  fwd_pkg::t_cmd              i_cmd,
    input  logic [1:0]                 i_operation,
    input  logic [7:0]                 i_value,
    output logic [1:0]                 o_status,
    output logic [7:0]                 o_popped,
    output logic [fwd_pkg::OCC_W-1:0]  o_occupancy
);

    fwd_pkg::t_byte   r_bytes [fwd_pkg::DEPTH];
    fwd_pkg::t_cnt    r_count;
    fwd_pkg::t_cnt    n_count;
    fwd_pkg::t_op     r_op;
    fwd_pkg::t_byte   r_val;
    fwd_pkg::t_status r_status;
    fwd_pkg::t_status n_status;
    fwd_pkg::t_byte   r_popped;
    fwd_pkg::t_byte   n_popped;

    fwd_pkg::t_vec valid;
    fwd_pkg::t_vec match;
    fwd_pkg::t_vec hit_upto;
    fwd_pkg::t_vec shift_en;
    fwd_pkg::t_vec wr_en;

    always_comb begin
        for (int i = 0; i < fwd_pkg::DEPTH; i++) begin
            valid[i]    = fwd_pkg::CNT_W'(i) < r_count;
            match[i]    = valid[i] && (r_bytes[i] == r_val);
            wr_en[i]    = fwd_pkg::CNT_W'(i) == r_count;
        end
        for (int i = 0; i < fwd_pkg::DEPTH; i++) begin
            hit_upto[i] = |(match & (fwd_pkg::t_vec'({fwd_pkg::DEPTH{1'b1}})
                                     >> (fwd_pkg::DEPTH - 1 - i)));
        end
    end

    always_comb begin
        n_count  = r_count;
        n_status = fwd_pkg::STAT_OK;
        n_popped = '0;
        shift_en = '0;
        unique case (r_op)
            fwd_pkg::OP_APPEND: begin
                if (r_count == fwd_pkg::CNT_W'(fwd_pkg::DEPTH)) begin
                    n_status = fwd_pkg::STAT_FULL;
                end else begin
                    n_count = r_count + 1'b1;
                end
            end
            fwd_pkg::OP_POP: begin
                if (r_count == '0) begin
                    n_status = fwd_pkg::STAT_EMPTY;
                end else begin
                    n_popped = r_bytes[0];
                    shift_en = '1;
                    n_count  = r_count - 1'b1;
                end
            end
            fwd_pkg::OP_DELETE: begin
                if (r_count == '0) begin
                    n_status = fwd_pkg::STAT_EMPTY;
                end else if (match == '0) begin
                    n_status = fwd_pkg::STAT_NOMATCH;
                end else begin
                    shift_en = hit_upto;
                    n_count  = r_count - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.exec) begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_op  <= fwd_pkg::t_op'(i_operation);
            r_val <= i_value;
        end
        if (i_cmd.exec) begin
            r_status <= n_status;
            r_popped <= n_popped;
        end
    end

    for (genvar g = 0; g < fwd_pkg::DEPTH; g++) begin : g_slot
        always_ff @(posedge i_clk) begin
            if (i_cmd.exec) begin
                if (r_op == fwd_pkg::OP_APPEND && wr_en[g]) begin
                    r_bytes[g] <= r_val;
                end else if (shift_en[g] && g < fwd_pkg::DEPTH - 1) begin
                    r_bytes[g] <= r_bytes[(g + 1) % fwd_pkg::DEPTH];
                end
            end
        end
    end

    assign o_status    = r_status;
    assign o_popped    = r_popped;
    assign o_occupancy = fwd_pkg::OCC_W'(r_count);

endmodule

// ===== sv/fifo_with_delete_by_value_core.sv =====
// ----------------------------------------------------------------------------
// fifo_with_delete_by_value_core
// Byte queue with append, pop and delete-first-match, one result per item.
// ----------------------------------------------------------------------------
// Channel   Handshake                 Payload
// command   start & !busy             i_operation, i_value
// result    o_valid (one cycle)       o_status, o_popped, o_occupancy
//
// Each item runs in two steps: load registers the command, execute compares
// all slots in parallel and shifts the slot row. The result strobes in the
// cycle after execute, and a new item can be taken in that same cycle.
// Synchronous reset empties the queue; slot bytes are not cleared.
// The receiver cannot stall; results are never held.
// ----------------------------------------------------------------------------
module fifo_with_delete_by_value_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                i_operation,
    input  logic [7:0]                i_value,
    output logic                      o_valid,
    output logic [1:0]                o_status,
    output logic [7:0]                o_popped,
    output logic [fwd_pkg::OCC_W-1:0] o_occupancy
);

    fwd_pkg::t_cmd cmd;

    fwd_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .o_busy  (busy),
        .o_done  (o_valid),
        .o_cmd   (cmd)
    );

    fwd_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_status    (o_status),
        .o_popped    (o_popped),
        .o_occupancy (o_occupancy)
    );

endmodule

// ===== sv/fwd_checker.sv =====
// ----------------------------------------------------------------------------
// fwd_checker
// Port-level checks for the byte queue core, bound to the top level.
// ----------------------------------------------------------------------------
module fwd_checker (
    input logic                      i_clk,
    input logic                      i_rst_n,
    input logic                      start,
    input logic                      busy,
    input logic                      o_valid,
    input logic [1:0]                o_status,
    input logic [7:0]                o_popped,
    input logic [fwd_pkg::OCC_W-1:0] o_occupancy
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##2 o_valid)
        else $error("result strobe missing after accepted item");

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_occupancy <= fwd_pkg::OCC_W'(fwd_pkg::DEPTH)))
        else $error("occupancy beyond depth");

    a_full_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status == fwd_pkg::STAT_FULL)
            |-> (o_occupancy == fwd_pkg::OCC_W'(fwd_pkg::DEPTH)))
        else $error("full status with queue not full");

    a_err_popped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != fwd_pkg::STAT_OK) |-> (o_popped == 8'd0))
        else $error("nonzero popped byte on failed operation");

endmodule

bind fifo_with_delete_by_value_core fwd_checker u_fwd_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_valid     (o_valid),
    .o_status    (o_status),
    .o_popped    (o_popped),
    .o_occupancy (o_occupancy)
);

// ===== sim/tb_fifo_with_delete_by_value_core.sv =====
// ----------------------------------------------------------------------------
// tb_fifo_with_delete_by_value_core
// Self-checking bench for the byte queue with append, pop and delete-match.
// A directed table covers the empty, full, no-match, duplicate and no-op
// cases. Random phases with varying append bias then fill and drain the
// queue. Each accepted item runs through a shadow queue; its prediction, or
// a typed row's table result, is compared field by field with each strobe.
// ----------------------------------------------------------------------------
module tb_fifo_with_delete_by_value_core;

    typedef struct packed {
        fwd_pkg::t_status             status;
        fwd_pkg::t_byte               popped;
        logic [fwd_pkg::OCC_W-1:0]    occupancy;
    } t_result;

    typedef struct packed {
        fwd_pkg::t_op    op;
        fwd_pkg::t_byte  value;
        logic            typed;
        t_result         res;
    } t_row;

    localparam int DIR_N   = 24;
    localparam int PHASE_N = 8;
    localparam int PHASE_LEN = 50;

    logic                       i_clk       = 1'b0;
    logic                       i_rst_n     = 1'b0;
    logic                       start       = 1'b0;
    logic [1:0]                 i_operation = 2'd0;
    logic [7:0]                 i_value     = 8'd0;
    logic                       busy;
    logic                       o_valid;
    logic [1:0]                 o_status;
    logic [7:0]                 o_popped;
    logic [fwd_pkg::OCC_W-1:0]  o_occupancy;

    fwd_pkg::t_byte shadow_bytes [fwd_pkg::DEPTH];
    int             shadow_len = 0;
    t_result        pending_results [$];
    t_row           dir_rows [DIR_N];
    int             errors = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    fifo_with_delete_by_value_core i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_operation (i_operation),
        .i_value     (i_value),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_popped    (o_popped),
        .o_occupancy (o_occupancy)
    );

    task automatic apply_queue_op(input fwd_pkg::t_op op, input fwd_pkg::t_byte val,
                                  output t_result res);
        int hit;
        int pos;
        res.status = fwd_pkg::STAT_OK;
        res.popped = 8'h00;
        hit = -1;
        case (op)
            fwd_pkg::OP_APPEND: begin
                if (shadow_len >= fwd_pkg::DEPTH) begin
                    res.status = fwd_pkg::STAT_FULL;
                end else begin
                    shadow_bytes[shadow_len] = val;
                    shadow_len++;
                end
            end
            fwd_pkg::OP_POP: begin
                if (shadow_len == 0) begin
                    res.status = fwd_pkg::STAT_EMPTY;
                end else begin
                    res.popped = shadow_bytes[0];
                    hit = 0;
                end
            end
            fwd_pkg::OP_DELETE: begin
                if (shadow_len == 0) begin
                    res.status = fwd_pkg::STAT_EMPTY;
                end else begin
                    for (pos = 0; pos < shadow_len; pos++) begin
                        if (hit < 0 && shadow_bytes[pos] == val) hit = pos;
                    end
                    if (hit < 0) res.status = fwd_pkg::STAT_NOMATCH;
                end
            end
            default: ;
        endcase
        if (hit >= 0) begin
            for (pos = hit; pos < shadow_len - 1; pos++) begin
                shadow_bytes[pos] = shadow_bytes[pos + 1];
            end
            shadow_len--;
        end
        res.occupancy = shadow_len[fwd_pkg::OCC_W-1:0];
    endtask

    task automatic send_item(input fwd_pkg::t_op op, input fwd_pkg::t_byte val,
                             input logic typed, input t_result typed_res);
        t_result res;
        start       <= 1'b1;
        i_operation <= op;
        i_value     <= val;
        do @(posedge i_clk); while (busy);
        apply_queue_op(op, val, res);
        pending_results.push_back(typed ? typed_res : res);
    endtask

    task automatic drain_results();
        start <= 1'b0;
        do @(posedge i_clk); while (pending_results.size() != 0);
    endtask

    always @(posedge i_clk) begin
        t_result exp_res;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $display("%0t: result with no item pending: status %0d popped %0h occ %0d",
                         $time, o_status, o_popped, o_occupancy);
                errors++;
            end else begin
                exp_res = pending_results.pop_front();
                if (o_status !== exp_res.status) begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, exp_res.status, o_status);
                    errors++;
                end
                if (o_popped !== exp_res.popped) begin
                    $display("%0t: popped expected %0h actual %0h",
                             $time, exp_res.popped, o_popped);
                    errors++;
                end
                if (o_occupancy !== exp_res.occupancy) begin
                    $display("%0t: occupancy expected %0d actual %0d",
                             $time, exp_res.occupancy, o_occupancy);
                    errors++;
                end
            end
        end
    end

    initial begin
        int             k;
        int             phase;
        int             n;
        int             burst_left;
        int             fill_pct;
        int             r;
        int             guard;
        logic           gaps_on;
        fwd_pkg::t_op   op;
        fwd_pkg::t_byte val;
        int             fill_bias [PHASE_N];

        dir_rows[0]  = '{fwd_pkg::OP_POP,    8'h00, 1'b1,
                         '{fwd_pkg::STAT_EMPTY, 8'h00, 5'd0}};
        dir_rows[1]  = '{fwd_pkg::OP_DELETE, 8'h00, 1'b1,
                         '{fwd_pkg::STAT_EMPTY, 8'h00, 5'd0}};
        dir_rows[2]  = '{fwd_pkg::OP_NOP,    8'hFF, 1'b1,
                         '{fwd_pkg::STAT_OK,    8'h00, 5'd0}};
        dir_rows[3]  = '{fwd_pkg::OP_APPEND, 8'h00, 1'b1,
                         '{fwd_pkg::STAT_OK,    8'h00, 5'd1}};
        dir_rows[4]  = '{fwd_pkg::OP_APPEND, 8'hFF, 1'b1,
                         '{fwd_pkg::STAT_OK,    8'h00, 5'd2}};
        dir_rows[5]  = '{fwd_pkg::OP_APPEND, 8'h5A, 1'b0, '0};
        dir_rows[6]  = '{fwd_pkg::OP_APPEND, 8'hFF, 1'b0, '0};
        dir_rows[7]  = '{fwd_pkg::OP_APPEND, 8'hA5, 1'b0, '0};
        dir_rows[8]  = '{fwd_pkg::OP_APPEND, 8'h01, 1'b0, '0};
        dir_rows[9]  = '{fwd_pkg::OP_APPEND, 8'h80, 1'b0, '0};
        dir_rows[10] = '{fwd_pkg::OP_APPEND, 8'h7F, 1'b0, '0};
        dir_rows[11] = '{fwd_pkg::OP_APPEND, 8'h10, 1'b0, '0};
        dir_rows[12] = '{fwd_pkg::OP_APPEND, 8'h20, 1'b0, '0};
        dir_rows[13] = '{fwd_pkg::OP_APPEND, 8'h40, 1'b0, '0};
        dir_rows[14] = '{fwd_pkg::OP_APPEND, 8'h02, 1'b0, '0};
        dir_rows[15] = '{fwd_pkg::OP_APPEND, 8'h04, 1'b0, '0};
        dir_rows[16] = '{fwd_pkg::OP_APPEND, 8'h08, 1'b0, '0};
        dir_rows[17] = '{fwd_pkg::OP_APPEND, 8'hFE, 1'b0, '0};
        dir_rows[18] = '{fwd_pkg::OP_APPEND, 8'h55, 1'b1,
                         '{fwd_pkg::STAT_OK,    8'h00, 5'd16}};
        dir_rows[19] = '{fwd_pkg::OP_APPEND, 8'h33, 1'b1,
                         '{fwd_pkg::STAT_FULL,  8'h00, 5'd16}};
        dir_rows[20] = '{fwd_pkg::OP_DELETE, 8'hFF, 1'b0, '0};
        dir_rows[21] = '{fwd_pkg::OP_DELETE, 8'h77, 1'b0, '0};
        dir_rows[22] = '{fwd_pkg::OP_DELETE, 8'h55, 1'b0, '0};
        dir_rows[23] = '{fwd_pkg::OP_POP,    8'h00, 1'b1,
                         '{fwd_pkg::STAT_OK,    8'h00, 5'd13}};

        fill_bias = '{85, 20, 60, 95, 10, 50, 70, 30};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (k = 0; k < DIR_N; k++) begin
            send_item(dir_rows[k].op, dir_rows[k].value, dir_rows[k].typed,
                      dir_rows[k].res);
            if ($urandom_range(0, 3) == 0) begin
                start <= 1'b0;
                repeat ($urandom_range(1, 4)) @(posedge i_clk);
            end
        end
        drain_results();

        burst_left = $urandom_range(1, 12);
        for (phase = 0; phase < PHASE_N; phase++) begin
            fill_pct = fill_bias[phase];
            gaps_on  = (phase != 2) && (phase != 5);
            for (n = 0; n < PHASE_LEN; n++) begin
                r = $urandom_range(0, 99);
                if (r < 4) begin
                    op = fwd_pkg::OP_NOP;
                end else if ($urandom_range(0, 99) < fill_pct) begin
                    op = fwd_pkg::OP_APPEND;
                end else if ($urandom_range(0, 1) == 0) begin
                    op = fwd_pkg::OP_POP;
                end else begin
                    op = fwd_pkg::OP_DELETE;
                end
                val = fwd_pkg::t_byte'($urandom_range(0, 255));
                if (op == fwd_pkg::OP_DELETE && shadow_len > 0
                        && $urandom_range(0, 9) < 7) begin
                    val = shadow_bytes[$urandom_range(0, shadow_len - 1)];
                end
                send_item(op, val, 1'b0, '0);
                burst_left--;
                if (burst_left == 0) begin
                    burst_left = $urandom_range(1, 12);
                    if (gaps_on) begin
                        start <= 1'b0;
                        repeat ($urandom_range(1, 6)) @(posedge i_clk);
                    end
                end
            end
            if (phase == 3) drain_results();
        end

        start <= 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < 2000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (10) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb_fifo_with_delete_by_value_core passed");
        end else begin
            $display("tb_fifo_with_delete_by_value_core failed");
        end
        $finish;
    end

    initial begin
        #800000;
        $display("tb_fifo_with_delete_by_value_core failed");
        $finish;
    end

endmodule
